@@ hw/rtl/mafs_pkg.sv @@
// ----------------------------------------------------------------------------
// mafs_pkg: MPEG audio frame size shared types and tables
// Bitrate tables, sample-rate divisor classes and the decode record
// passed from the header decoder into the length pipeline.
// ----------------------------------------------------------------------------
package mafs_pkg;

	localparam int HdrW   = 24;
	localparam int BytesW = 12;
	localparam int KbpsW  = 9;
	localparam int CoefW  = 13;
	localparam int NumW   = 20;
	localparam int RecipW = 26;
	localparam int DivW   = 9;
	localparam int PadW   = 3;
	localparam int RecipShift = 30;

	// version codes
	localparam logic [1:0] VER_25  = 2'b00;
	localparam logic [1:0] VER_RSV = 2'b01;
	localparam logic [1:0] VER_2   = 2'b10;
	localparam logic [1:0] VER_1   = 2'b11;

	// layer codes
	localparam logic [1:0] LAY_RSV = 2'b00;
	localparam logic [1:0] LAY_3   = 2'b01;
	localparam logic [1:0] LAY_2   = 2'b10;
	localparam logic [1:0] LAY_1   = 2'b11;

	localparam logic [3:0] BRI_BAD = 4'd15;
	localparam logic [1:0] SRI_BAD = 2'd3;

	// sample rate family: rate = base / 2^k, 1000/base reduces to 10/441, 1/48, 1/32
	typedef enum logic [1:0] {
		DIV_441 = 2'd0,
		DIV_48  = 2'd1,
		DIV_32  = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic               ok;
		logic [CoefW-1:0]   coef;     // spf/8 * 2^k, times 10 for the 44.1k family
		logic [KbpsW-1:0]   kbps;
		div_sel_t           dsel;
		logic [PadW-1:0]    pad_add;
	} mafs_dec_t;

	function automatic logic [DivW-1:0] mafs_divisor(input div_sel_t d);
		logic [DivW-1:0] r;
		case (d)
			DIV_441: r = 9'd441;
			DIV_48:  r = 9'd48;
			default: r = 9'd32;
		endcase
		return r;
	endfunction

	// floor(2^30 / divisor); estimate lands at q or q-1
	function automatic logic [RecipW-1:0] mafs_recip(input div_sel_t d);
		logic [RecipW-1:0] r;
		case (d)
			DIV_441: r = 26'd2434788;
			DIV_48:  r = 26'd22369621;
			default: r = 26'd33554432;
		endcase
		return r;
	endfunction

	function automatic logic [KbpsW-1:0] mafs_kbps(input logic [1:0] ver,
			input logic [1:0] lay, input logic [3:0] bri);
		logic [KbpsW-1:0] r;
		r = '0;
		if (ver == VER_1) begin
			unique case (lay)
				LAY_1: case (bri)
					4'd1: r = 9'd32;   4'd2: r = 9'd64;   4'd3: r = 9'd96;
					4'd4: r = 9'd128;  4'd5: r = 9'd160;  4'd6: r = 9'd192;
					4'd7: r = 9'd224;  4'd8: r = 9'd256;  4'd9: r = 9'd288;
					4'd10: r = 9'd320; 4'd11: r = 9'd352; 4'd12: r = 9'd384;
					4'd13: r = 9'd416; 4'd14: r = 9'd448; default: r = '0;
				endcase
				LAY_2: case (bri)
					4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;
					4'd4: r = 9'd64;   4'd5: r = 9'd80;   4'd6: r = 9'd96;
					4'd7: r = 9'd112;  4'd8: r = 9'd128;  4'd9: r = 9'd160;
					4'd10: r = 9'd192; 4'd11: r = 9'd224; 4'd12: r = 9'd256;
					4'd13: r = 9'd320; 4'd14: r = 9'd384; default: r = '0;
				endcase
				default: case (bri)
					4'd1: r = 9'd32;   4'd2: r = 9'd40;   4'd3: r = 9'd48;
					4'd4: r = 9'd56;   4'd5: r = 9'd64;   4'd6: r = 9'd80;
					4'd7: r = 9'd96;   4'd8: r = 9'd112;  4'd9: r = 9'd128;
					4'd10: r = 9'd160; 4'd11: r = 9'd192; 4'd12: r = 9'd224;
					4'd13: r = 9'd256; 4'd14: r = 9'd320; default: r = '0;
				endcase
			endcase
		end else if (lay == LAY_1) begin
			case (bri)
				4'd1: r = 9'd32;   4'd2: r = 9'd48;   4'd3: r = 9'd56;
				4'd4: r = 9'd64;   4'd5: r = 9'd80;   4'd6: r = 9'd96;
				4'd7: r = 9'd112;  4'd8: r = 9'd128;  4'd9: r = 9'd144;
				4'd10: r = 9'd160; 4'd11: r = 9'd176; 4'd12: r = 9'd192;
				4'd13: r = 9'd224; 4'd14: r = 9'd256; default: r = '0;
			endcase
		end else begin
			case (bri)
				4'd1: r = 9'd8;    4'd2: r = 9'd16;   4'd3: r = 9'd24;
				4'd4: r = 9'd32;   4'd5: r = 9'd40;   4'd6: r = 9'd48;
				4'd7: r = 9'd56;   4'd8: r = 9'd64;   4'd9: r = 9'd80;
				4'd10: r = 9'd96;  4'd11: r = 9'd112; 4'd12: r = 9'd128;
				4'd13: r = 9'd144; 4'd14: r = 9'd160; default: r = '0;
			endcase
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/mafs_decode.sv @@
// ----------------------------------------------------------------------------
// mafs_decode: header field decoder
// Checks sync and reserved codes, looks up bitrate and builds the scaled
// numerator coefficient and divisor class for the length pipeline.
// ----------------------------------------------------------------------------
module mafs_decode (
	input  logic [mafs_pkg::HdrW-1:0] header_word,
	output mafs_pkg::mafs_dec_t       dec
);
	import mafs_pkg::*;

	logic [7:0]  b0, b1, b2;
	logic [1:0]  ver, lay, sri;
	logic [3:0]  bri;
	logic        pad;
	logic [7:0]  spf8;
	logic [CoefW-1:0] base_c;
	logic [1:0]  ksh;

	assign b0  = header_word[23:16];
	assign b1  = header_word[15:8];
	assign b2  = header_word[7:0];
	assign ver = b1[4:3];
	assign lay = b1[2:1];
	assign bri = b2[7:4];
	assign sri = b2[3:2];
	assign pad = b2[1];

	always_comb begin
		dec.ok = (b0 == 8'hFF) && (b1[7:5] == 3'b111) && (ver != VER_RSV) &&
			(lay != LAY_RSV) && (bri != BRI_BAD) && (sri != SRI_BAD);

		unique case (lay)
			LAY_1:   spf8 = 8'd48;
			LAY_2:   spf8 = 8'd144;
			default: spf8 = (ver == VER_1) ? 8'd144 : 8'd72;
		endcase

		// halved sample rate doubles the quotient
		unique case (ver)
			VER_1:   ksh = 2'd0;
			VER_2:   ksh = 2'd1;
			default: ksh = 2'd2;
		endcase

		unique case (sri)
			2'd0:    dec.dsel = DIV_441;
			2'd1:    dec.dsel = DIV_48;
			default: dec.dsel = DIV_32;
		endcase

		base_c = {5'd0, spf8} << ksh;
		dec.coef = (dec.dsel == DIV_441) ? ((base_c << 3) + (base_c << 1)) : base_c;
		dec.kbps = mafs_kbps(ver, lay, bri);

		if (!pad)
			dec.pad_add = '0;
		else if (lay == LAY_1)
			dec.pad_add = 3'd4;
		else
			dec.pad_add = 3'd1;
	end

endmodule

@@ hw/rtl/mpeg_audio_frame_size_top.sv @@
// ----------------------------------------------------------------------------
// mpeg_audio_frame_size_top: MPEG audio frame length from a header
// Five-stage pipeline: decode, numerator product, reciprocal multiply,
// back-multiply, remainder fix-up with padding.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid / in_stall   | header_word[23:0]
//  out     | source    | out_valid / out_stall | frame_bytes[11:0], header_valid
//
// One header per cycle while the output is not stalled, with the 20x26 reciprocal
// multiply and the 12x9 back-multiply each in a pipeline stage of their own.
// arst_n clears the stage valid bits only.
// Each stage holds when the next one is full and stalled, so bubbles fill in
// while the output waits; in_stall rises only when all five stages are full.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_size_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mafs_pkg::HdrW-1:0]     header_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mafs_pkg::BytesW-1:0]   frame_bytes,
	output logic                          header_valid
);
	import mafs_pkg::*;

	localparam int ProdW = NumW + RecipW;
	localparam int QdW   = BytesW + DivW;

	mafs_dec_t dec;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	mafs_dec_t          dec_s1;
	logic               ok_s2, ok_s3, ok_s4;
	div_sel_t           dsel_s2, dsel_s3, dsel_s4;
	logic [PadW-1:0]    pad_s2, pad_s3, pad_s4;
	logic [NumW-1:0]    num_s2, num_s3, num_s4;
	logic [BytesW-1:0]  q0_s3, q0_s4;
	logic [QdW-1:0]     qd_s4;
	logic [BytesW-1:0]  bytes_s5;
	logic               ok_s5;

	logic [CoefW+KbpsW-1:0] num_full;
	logic [ProdW-1:0]       prod;
	logic [QdW-1:0]         qd;
	logic [NumW-1:0]        rem;
	logic                   fix;

	mafs_decode u_decode (
		.header_word (header_word),
		.dec         (dec)
	);

	assign en5 = !v_s5 || !out_stall;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	assign num_full = dec_s1.coef * dec_s1.kbps;
	assign prod     = num_s2 * mafs_recip(dsel_s2);
	assign qd       = q0_s3 * mafs_divisor(dsel_s3);
	assign rem      = num_s4 - qd_s4[NumW-1:0];
	// estimate is short by at most one
	assign fix      = (rem >= {{(NumW-DivW){1'b0}}, mafs_divisor(dsel_s4)});

	always_ff @(posedge clk) begin
		if (en1)
			dec_s1 <= dec;
		if (en2) begin
			ok_s2   <= dec_s1.ok;
			dsel_s2 <= dec_s1.dsel;
			pad_s2  <= dec_s1.pad_add;
			num_s2  <= num_full[NumW-1:0];
		end
		if (en3) begin
			ok_s3   <= ok_s2;
			dsel_s3 <= dsel_s2;
			pad_s3  <= pad_s2;
			num_s3  <= num_s2;
			q0_s3   <= prod[RecipShift +: BytesW];
		end
		if (en4) begin
			ok_s4   <= ok_s3;
			dsel_s4 <= dsel_s3;
			pad_s4  <= pad_s3;
			num_s4  <= num_s3;
			q0_s4   <= q0_s3;
			qd_s4   <= qd;
		end
		if (en5) begin
			ok_s5    <= ok_s4;
			bytes_s5 <= ok_s4 ? (q0_s4 + {{(BytesW-1){1'b0}}, fix} +
				{{(BytesW-PadW){1'b0}}, pad_s4}) : '0;
		end
	end

	assign out_valid    = v_s5;
	assign frame_bytes  = bytes_s5;
	assign header_valid = ok_s5;

endmodule

@@ hw/rtl/mafs_chk.sv @@
// ----------------------------------------------------------------------------
// mafs_chk: port-level checker for the frame size block
// Watches the top-level ports; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module mafs_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [mafs_pkg::BytesW-1:0] frame_bytes,
	input logic                        header_valid
);
	import mafs_pkg::*;

	// a rejected header always reports zero length
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !header_valid |-> frame_bytes == '0)
		else $error("rejected header with nonzero length");

	// largest legal frame is a padded layer 2 frame
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_bytes <= 12'd2881)
		else $error("frame length out of range");

	// input backpressure only when the output is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a stalled transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_bytes) &&
			$stable(header_valid))
		else $error("stalled output changed");

endmodule

bind mpeg_audio_frame_size_top mafs_chk u_mafs_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.frame_bytes  (frame_bytes),
	.header_valid (header_valid)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for mpeg_audio_frame_size_top
// Sends directed and random 24-bit candidate headers through the valid/stall
// input channel, predicts frame length and header validity for each transfer,
// and checks every output transfer in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

	import mafs_pkg::*;

	localparam int NumRandom  = 700;
	localparam int IdleLimit  = 2000;
	localparam int IdlePct    = 11;

	// bitrates in kbit/s by index; free format and the bad index read as 0
	localparam logic [0:15][8:0] KBPS_V1_L1 = {9'd0, 9'd32, 9'd64, 9'd96, 9'd128,
		9'd160, 9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416,
		9'd448, 9'd0};
	localparam logic [0:15][8:0] KBPS_V1_L2 = {9'd0, 9'd32, 9'd48, 9'd56, 9'd64,
		9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320,
		9'd384, 9'd0};
	localparam logic [0:15][8:0] KBPS_V1_L3 = {9'd0, 9'd32, 9'd40, 9'd48, 9'd56,
		9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256,
		9'd320, 9'd0};
	localparam logic [0:15][8:0] KBPS_LSF_L1 = {9'd0, 9'd32, 9'd48, 9'd56, 9'd64,
		9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224,
		9'd256, 9'd0};
	localparam logic [0:15][8:0] KBPS_LSF_L23 = {9'd0, 9'd8, 9'd16, 9'd24, 9'd32,
		9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144,
		9'd160, 9'd0};

	localparam logic [0:3][16:0] SRATE_V1  = {17'd44100, 17'd48000, 17'd32000, 17'd0};
	localparam logic [0:3][16:0] SRATE_V2  = {17'd22050, 17'd24000, 17'd16000, 17'd0};
	localparam logic [0:3][16:0] SRATE_V25 = {17'd11025, 17'd12000, 17'd8000, 17'd0};

	typedef struct {
		logic [BytesW-1:0] nbytes;
		logic              ok;
	} frame_len_t;

	class frame_len_board;
		frame_len_t pending[$];
		int errors = 0;

		function frame_len_t frame_length(logic [HdrW-1:0] w);
			frame_len_t r;
			logic [1:0] ver, lay, sri;
			logic [3:0] bri;
			int unsigned spf8, kbps, rate, unit_b, len;
			ver = w[12:11];
			lay = w[10:9];
			bri = w[7:4];
			sri = w[3:2];
			r.nbytes = '0;
			r.ok = 1'b0;
			if (w[23:16] != 8'hFF || w[15:13] != 3'b111 || ver == VER_RSV ||
					lay == LAY_RSV || bri == BRI_BAD || sri == SRI_BAD)
				return r;
			case (lay)
				LAY_1: begin
					spf8 = 48;
					unit_b = 4;
					kbps = (ver == VER_1) ? KBPS_V1_L1[bri] : KBPS_LSF_L1[bri];
				end
				LAY_2: begin
					spf8 = 144;
					unit_b = 1;
					kbps = (ver == VER_1) ? KBPS_V1_L2[bri] : KBPS_LSF_L23[bri];
				end
				default: begin
					// layer 3 halves the frame for the low sample-rate versions
					spf8 = (ver == VER_1) ? 144 : 72;
					unit_b = 1;
					kbps = (ver == VER_1) ? KBPS_V1_L3[bri] : KBPS_LSF_L23[bri];
				end
			endcase
			case (ver)
				VER_1:   rate = SRATE_V1[sri];
				VER_2:   rate = SRATE_V2[sri];
				default: rate = SRATE_V25[sri];
			endcase
			len = spf8 * kbps * 1000 / rate;
			if (w[1])
				len += unit_b;
			r.nbytes = len[BytesW-1:0];
			r.ok = 1'b1;
			return r;
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		function void note_header(logic [HdrW-1:0] w);
			pending.push_back(frame_length(w));
		endfunction

		task check_result(logic [BytesW-1:0] nbytes, logic ok);
			frame_len_t e;
			if (pending.size() == 0) begin
				report("output transfer with nothing outstanding");
				return;
			end
			e = pending.pop_front();
			if (nbytes !== e.nbytes)
				report($sformatf("frame_bytes %0d, want %0d", nbytes, e.nbytes));
			if (ok !== e.ok)
				report($sformatf("header_valid %b, want %b", ok, e.ok));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [HdrW-1:0]   header_word;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [BytesW-1:0] frame_bytes;
	logic              header_valid;

	logic calm = 1'b0;
	int   idle_cycles = 0;
	frame_len_board board = new();

	mpeg_audio_frame_size_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.header_word  (header_word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_bytes  (frame_bytes),
		.header_valid (header_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < IdlePct);

	// transfer monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_header(header_word);
			if (out_valid && !out_stall)
				board.check_result(frame_bytes, header_valid);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else if (idle_cycles >= IdleLimit) begin
				$display("watchdog: no transfer in %0d cycles", IdleLimit);
				$display("FAIL");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [HdrW-1:0] build_header(logic [1:0] ver, logic [1:0] lay,
			logic [3:0] bri, logic [1:0] sri, logic pad);
		logic prot, priv;
		prot = 1'($urandom_range(1));
		priv = 1'($urandom_range(1));
		return {8'hFF, 3'b111, ver, lay, prot, bri, sri, pad, priv};
	endfunction

	function automatic logic [HdrW-1:0] random_header();
		logic [HdrW-1:0] w;
		logic [1:0] ver;
		int kind;
		kind = $urandom_range(99);
		case ($urandom_range(2))
			0:       ver = VER_1;
			1:       ver = VER_2;
			default: ver = VER_25;
		endcase
		w = build_header(ver, 2'($urandom_range(LAY_1, LAY_3)), 4'($urandom_range(14)),
			2'($urandom_range(2)), 1'($urandom_range(1)));
		if (kind >= 94)
			w = HdrW'($urandom);
		else if (kind >= 88) begin
			kind = $urandom_range(23, 13);
			w[kind] = ~w[kind];
		end else if (kind >= 75) begin
			case ($urandom_range(3))
				0:       w[12:11] = VER_RSV;
				1:       w[10:9] = LAY_RSV;
				2:       w[7:4] = BRI_BAD;
				default: w[3:2] = SRI_BAD;
			endcase
		end
		return w;
	endfunction

	task automatic send_header(logic [HdrW-1:0] w);
		while (!calm && $urandom_range(99) < IdlePct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		header_word <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		header_word = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_header(24'h000000);
		send_header(24'hFFFFFF);
		// every version and layer at the top bitrate, padded
		n = 0;
		for (int v = VER_25; v <= VER_1; v++) begin
			if (v != VER_RSV) begin
				for (int l = LAY_3; l <= LAY_1; l++) begin
					send_header(build_header(2'(v), 2'(l), 4'd14, 2'(n % 3), 1'b1));
					n++;
				end
			end
		end
		for (int l = LAY_3; l <= LAY_1; l++)
			send_header(build_header(VER_1, 2'(l), 4'd1, 2'd2, 1'b0));
		// largest length of all
		send_header(build_header(VER_25, LAY_2, 4'd14, 2'd2, 1'b1));
		// free format: only the padding term
		send_header(build_header(VER_1, LAY_1, 4'd0, 2'd0, 1'b1));
		send_header(build_header(VER_2, LAY_3, 4'd0, 2'd1, 1'b0));
		// each rejected field on its own
		send_header(build_header(VER_RSV, LAY_2, 4'd5, 2'd0, 1'b1));
		send_header(build_header(VER_1, LAY_RSV, 4'd5, 2'd0, 1'b1));
		send_header(build_header(VER_1, LAY_3, BRI_BAD, 2'd0, 1'b1));
		send_header(build_header(VER_2, LAY_1, 4'd5, SRI_BAD, 1'b1));
		send_header(24'hFEFB90);
		send_header(24'hFFDB90);

		for (int i = 0; i < NumRandom; i++) begin
			calm = (i >= 250 && i < 400);
			send_header(random_header());
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ mpeg_audio_frame_size_top.f @@
hw/rtl/mafs_pkg.sv
hw/rtl/mafs_decode.sv
hw/rtl/mpeg_audio_frame_size_top.sv
hw/rtl/mafs_chk.sv
test/tb_top.sv
